// ===== src/mm32_pkg.sv =====
// Shared types, widths and helpers for the 32-bit modular multiplier.
// No dependencies; imported by every module of the block.
package mm32_pkg;

  localparam int unsigned MM_WIDTH = 32;
  localparam int unsigned MM_CNT_W = $clog2(MM_WIDTH);

  // Control from the sequencer to a serial datapath unit
  typedef struct packed {
    logic load;
    logic step;
  } mm_ctrl_t;

  // Subtract the modulus once if the widened sum reaches it
  function automatic logic [MM_WIDTH-1:0] cond_sub(input logic [MM_WIDTH:0] sum,
                                                   input logic [MM_WIDTH-1:0] m);
    logic [MM_WIDTH:0] diff;
    diff = sum - {1'b0, m};
    if (sum >= {1'b0, m}) begin
      cond_sub = diff[MM_WIDTH-1:0];
    end else begin
      cond_sub = sum[MM_WIDTH-1:0];
    end
  endfunction

endpackage

// ===== src/mm32_reduce.sv =====
// Bit-serial restoring remainder: reduces a factor by the modulus,
// one dividend bit per step. Depends on mm32_pkg.
module mm32_reduce
  import mm32_pkg::*;
(
  input  logic                clk,
  input  mm_ctrl_t            ctrl,
  input  logic [MM_WIDTH-1:0] dividend,
  input  logic [MM_WIDTH-1:0] modulus,
  output logic [MM_WIDTH-1:0] remainder
);

  logic [MM_WIDTH-1:0] shift;
  logic [MM_WIDTH-1:0] rem;
  logic [MM_WIDTH:0]   trial;

  assign trial     = {rem, shift[MM_WIDTH-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shift <= dividend;
      rem   <= '0;
    end else if (ctrl.step) begin
      // bring in the next dividend bit, MSB first
      shift <= {shift[MM_WIDTH-2:0], 1'b0};
      rem   <= cond_sub(trial, modulus);
    end
  end

endmodule

// ===== src/mm32_ladder.sv =====
// Add-and-double ladder over the bits of the second factor, each sum
// reduced by one conditional subtract. Depends on mm32_pkg.
module mm32_ladder
  import mm32_pkg::*;
(
  input  logic                clk,
  input  mm_ctrl_t            ctrl,
  input  logic [MM_WIDTH-1:0] addend,
  input  logic [MM_WIDTH-1:0] multiplier,
  input  logic [MM_WIDTH-1:0] modulus,
  output logic [MM_WIDTH-1:0] acc_out
);

  logic [MM_WIDTH-1:0] acc;
  logic [MM_WIDTH-1:0] dbl;
  logic [MM_WIDTH-1:0] bsh;

  assign acc_out = acc;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= '0;
      dbl <= addend;
      bsh <= multiplier;
    end else if (ctrl.step) begin
      if (bsh[0]) begin
        acc <= cond_sub({1'b0, acc} + {1'b0, dbl}, modulus);
      end
      dbl <= cond_sub({dbl, 1'b0}, modulus);
      // advance to the next multiplier bit, LSB first
      bsh <= {1'b0, bsh[MM_WIDTH-1:1]};
    end
  end

endmodule

// ===== src/modular_multiply_32.sv =====
// Usage:
//   Command port: factor_a, factor_b and modulus are transferred at a rising
//   edge with start high and busy low. busy stays high until the result has
//   been shown; one item is worked on at a time.
//   Result port: product_mod is valid for exactly one cycle with done high.
//   The receiver cannot stall; a result not taken in that cycle is lost.
//   Sequence: done follows the command transfer once the serial datapath has
//   finished, and a new command may be transferred in the cycle after done, so
//   the block takes a new item only when it is through with the last one. The
//   datapath runs 32 steps of the bit-serial remainder unit reducing factor_a,
//   a load state for the ladder, 32 add-and-double steps over factor_b, and a
//   state showing done. A modulus of 0 or 1 gives 0 through the same states.
//   Reset (rst, synchronous, active high) returns the sequencer to idle and
//   drops any item in flight; no clearing pass is needed.
// Depends on mm32_pkg, mm32_reduce and mm32_ladder.
module modular_multiply_32
  import mm32_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MM_WIDTH-1:0] factor_a,
  input  logic [MM_WIDTH-1:0] factor_b,
  input  logic [MM_WIDTH-1:0] modulus,
  output logic                done,
  output logic [MM_WIDTH-1:0] product_mod
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_LAD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [MM_CNT_W-1:0] CNT_LAST = MM_CNT_W'(MM_WIDTH - 1);

  logic [2:0]          state, state_next;
  logic [MM_CNT_W-1:0] cnt, cnt_next;
  logic [MM_WIDTH-1:0] m_hold;
  logic [MM_WIDTH-1:0] b_hold;
  logic                trivial;
  logic                accept;
  mm_ctrl_t            red_ctrl, lad_ctrl;
  logic [MM_WIDTH-1:0] red_rem;
  logic [MM_WIDTH-1:0] lad_acc;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign product_mod = trivial ? '0 : lad_acc;

  assign red_ctrl.load = accept;
  assign red_ctrl.step = (state == S_RED);
  assign lad_ctrl.load = (state == S_LOAD);
  assign lad_ctrl.step = (state == S_LAD);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RED;
          cnt_next   = '0;
        end
      end
      S_RED: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_LAD;
        cnt_next   = '0;
      end
      S_LAD: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // hold the modulus and factor_b, and flag a trivial modulus, for the whole item
  always_ff @(posedge clk) begin
    if (accept) begin
      m_hold  <= modulus;
      b_hold  <= factor_b;
      trivial <= (modulus[MM_WIDTH-1:1] == '0);
    end
  end

  mm32_reduce u_reduce (
    .clk       (clk),
    .ctrl      (red_ctrl),
    .dividend  (factor_a),
    .modulus   (m_hold),
    .remainder (red_rem)
  );

  mm32_ladder u_ladder (
    .clk        (clk),
    .ctrl       (lad_ctrl),
    .addend     (red_rem),
    .multiplier (b_hold),
    .modulus    (m_hold),
    .acc_out    (lad_acc)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("busy not raised after a command transfer");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  a_below_mod: assert property (@(posedge clk) disable iff (rst)
    done && !trivial |-> product_mod < m_hold)
    else $error("result not below the modulus");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    lad_ctrl.load |-> $past(red_ctrl.step) && !red_ctrl.step)
    else $error("ladder loaded before reduction finished");
`endif

endmodule

// ===== dv/modular_multiply_32_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modular_multiply_32: directed corner commands, then random ones.
// A scoreboard class predicts each product and checks it. Depends on mm32_pkg and the block.
module modular_multiply_32_tb
  import mm32_pkg::*;
;

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CALM_ITEMS   = 100;  // final stretch with no sender idling
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [MM_WIDTH-1:0] ALL_ONES = '1;
  localparam logic [MM_WIDTH-1:0] TOP_BIT  = {1'b1, {(MM_WIDTH-1){1'b0}}};

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [MM_WIDTH-1:0] factor_a;
  logic [MM_WIDTH-1:0] factor_b;
  logic [MM_WIDTH-1:0] modulus;
  logic                done;
  logic [MM_WIDTH-1:0] product_mod;

  class product_scoreboard;
    logic [MM_WIDTH-1:0] pending_products[$];
    logic [MM_WIDTH-1:0] pending_a[$];
    logic [MM_WIDTH-1:0] pending_b[$];
    logic [MM_WIDTH-1:0] pending_m[$];
    int unsigned         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Sum of two residues below m, reduced without widening
    function logic [MM_WIDTH-1:0] add_residues(logic [MM_WIDTH-1:0] x, logic [MM_WIDTH-1:0] y,
                                               logic [MM_WIDTH-1:0] m);
      logic [MM_WIDTH-1:0] gap;
      gap = m - x;
      return (y >= gap) ? (y - gap) : (x + y);
    endfunction

    function logic [MM_WIDTH-1:0] mod_product(logic [MM_WIDTH-1:0] a, logic [MM_WIDTH-1:0] b,
                                              logic [MM_WIDTH-1:0] m);
      logic [MM_WIDTH-1:0] doubled;
      logic [MM_WIDTH-1:0] scan;
      logic [MM_WIDTH-1:0] acc;
      if (m < 2) return '0;
      doubled = a % m;
      scan    = b % m;
      acc     = '0;
      for (int i = 0; i < MM_WIDTH; i++) begin
        if (scan[i]) acc = add_residues(acc, doubled, m);
        doubled = add_residues(doubled, doubled, m);
      end
      return acc;
    endfunction

    function void note_command(logic [MM_WIDTH-1:0] a, logic [MM_WIDTH-1:0] b,
                               logic [MM_WIDTH-1:0] m);
      pending_products.push_back(mod_product(a, b, m));
      pending_a.push_back(a);
      pending_b.push_back(b);
      pending_m.push_back(m);
    endfunction

    function void check_result(logic [MM_WIDTH-1:0] actual);
      logic [MM_WIDTH-1:0] want;
      logic [MM_WIDTH-1:0] a;
      logic [MM_WIDTH-1:0] b;
      logic [MM_WIDTH-1:0] m;
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: unexpected result product_mod=%h with no command pending", actual);
        return;
      end
      want = pending_products.pop_front();
      a    = pending_a.pop_front();
      b    = pending_b.pop_front();
      m    = pending_m.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: a=%h b=%h m=%h product_mod expected %h actual %h",
                   a, b, m, want, actual);
      end
    endfunction

    function int unsigned outstanding();
      return pending_products.size();
    endfunction
  endclass

  product_scoreboard scoreboard;

  modular_multiply_32 dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .factor_a    (factor_a),
    .factor_b    (factor_b),
    .modulus     (modulus),
    .done        (done),
    .product_mod (product_mod)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Check a finished product before noting a transfer on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) scoreboard.check_result(product_mod);
      if (start && !busy) scoreboard.note_command(factor_a, factor_b, modulus);
    end
  end

  function automatic logic [MM_WIDTH-1:0] random_word();
    return $urandom();
  endfunction

  // Pick a value from one of several regions so that corners come up often
  function automatic logic [MM_WIDTH-1:0] pick_modulus();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(2, 255);
      2:       return ALL_ONES - $urandom_range(0, 15);
      3:       return TOP_BIT + $urandom_range(0, 15) - 8;
      default: return random_word();
    endcase
  endfunction

  function automatic logic [MM_WIDTH-1:0] pick_factor(logic [MM_WIDTH-1:0] m);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES - $urandom_range(0, 3);
      2:       return m - $urandom_range(0, 2);
      3:       return m + $urandom_range(0, 2);
      4:       return $urandom_range(0, 7);
      default: return random_word();
    endcase
  endfunction

  // Present a command at the current falling edge and hold it until transferred
  task automatic transfer_command(logic [MM_WIDTH-1:0] a, logic [MM_WIDTH-1:0] b,
                                  logic [MM_WIDTH-1:0] m);
    start    <= 1'b1;
    factor_a <= a;
    factor_b <= b;
    modulus  <= m;
    do @(posedge clk); while (!(start && !busy));
    @(negedge clk);
  endtask

  // Drop start for a short burst, optionally after the block has finished
  task automatic idle_burst(bit after_done);
    if (after_done)
      while (busy) @(negedge clk);
    start    <= 1'b0;
    factor_a <= random_word();
    factor_b <= random_word();
    modulus  <= random_word();
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(0, 2) == 0) idle_burst($urandom_range(0, 1));
  endtask

  initial begin
    logic [MM_WIDTH-1:0] m;
    scoreboard = new();
    rst      = 1'b1;
    start    = 1'b0;
    factor_a = '0;
    factor_b = '0;
    modulus  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero and unit moduli, zero factors, extremes and factors above the modulus
    transfer_command(ALL_ONES, ALL_ONES, '0);               maybe_idle(1);
    transfer_command(ALL_ONES, ALL_ONES, 32'd1);            maybe_idle(1);
    transfer_command('0, ALL_ONES, ALL_ONES - 1);           maybe_idle(1);
    transfer_command(ALL_ONES, '0, ALL_ONES - 1);           maybe_idle(1);
    transfer_command('0, '0, 32'd2);                        maybe_idle(1);
    transfer_command(ALL_ONES, ALL_ONES, ALL_ONES);         maybe_idle(1);
    transfer_command(ALL_ONES - 1, ALL_ONES - 1, ALL_ONES); maybe_idle(1);
    transfer_command(ALL_ONES, ALL_ONES, ALL_ONES - 1);     maybe_idle(1);
    transfer_command(ALL_ONES, ALL_ONES, 32'd2);            maybe_idle(1);
    transfer_command(ALL_ONES, ALL_ONES, 32'd3);            maybe_idle(1);
    transfer_command(TOP_BIT, TOP_BIT, ALL_ONES);           maybe_idle(1);
    transfer_command(TOP_BIT, 32'd2, TOP_BIT + 1);          maybe_idle(1);
    transfer_command(TOP_BIT - 1, TOP_BIT - 1, TOP_BIT);    maybe_idle(1);
    transfer_command(32'd1, 32'd1, ALL_ONES);               maybe_idle(1);
    transfer_command(32'd1, ALL_ONES - 1, ALL_ONES);        maybe_idle(1);
    transfer_command(32'd7, 32'd7, 32'd7);                  maybe_idle(1);
    transfer_command(32'd8, 32'd9, 32'd7);                  maybe_idle(1);
    transfer_command(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFB); maybe_idle(1);
    transfer_command(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001); maybe_idle(1);
    transfer_command(32'h1234_5678, 32'h9ABC_DEF0, '0);     maybe_idle(1);
    transfer_command(32'h1234_5678, 32'h9ABC_DEF0, 32'd1);  maybe_idle(1);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      m = pick_modulus();
      transfer_command(pick_factor(m), pick_factor(m), m);
      maybe_idle(n < RANDOM_ITEMS - CALM_ITEMS);
    end
    start <= 1'b0;

    // Poll each cycle until every transferred command has produced its result
    while (scoreboard.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
      $display("modular_multiply_32 verification clean");
    end else begin
      $display("modular_multiply_32 verification failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("modular_multiply_32 verification failed");
    $finish;
  end

endmodule
